// ----- hw/rtl/conv_pkg.sv -----
// ----------------------------------------------------------------------------
// conv_pkg
// Shared types, constants and tap tables for the 3x3 wrap-around filter.
// ----------------------------------------------------------------------------
package conv_pkg;

    localparam int MAX_SIDE_DEF = 256;
    localparam int CFG_AW       = 5;
    localparam int CFG_DW       = 32;
    localparam int PIX_W        = 8;
    localparam int COEF_W       = 8;
    localparam int ACC_W        = 20;
    localparam int DIVR_W       = 12;
    localparam int MASK_W       = 24;
    localparam int SIDE_REG_W   = 9;

    localparam logic [3:0] TAP_LAST = 4'd8;
    localparam logic [1:0] ROW_LAST = 2'd2;

    typedef enum logic [2:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_MASK_TOP,
        REG_MASK_MID,
        REG_MASK_BOT,
        REG_DIVIDER,
        REG_CROP
    } reg_idx_t;

    typedef struct packed {
        logic [SIDE_REG_W-1:0] frame_width;
        logic [SIDE_REG_W-1:0] frame_height;
        logic [MASK_W-1:0]     mask_top_row;
        logic [MASK_W-1:0]     mask_middle_row;
        logic [MASK_W-1:0]     mask_bottom_row;
        logic [DIVR_W-1:0]     divider_setting;
        logic                  crop_mode;
    } cfg_t;

    typedef struct packed {
        logic       accept;
        logic       pos_start;
        logic       pos_capture;
        logic       row_mul;
        logic [1:0] row;
        logic       tap_rd;
        logic       tap_mac;
        logic [3:0] tap;
        logic       res_start;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic d_zero;
        logic out_free;
    } sts_t;

    function automatic logic [1:0] tap_row(input logic [3:0] t);
        logic [1:0] r;
        case (t)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] tap_col(input logic [3:0] t);
        logic [1:0] c;
        case (t)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            4'd2, 4'd5, 4'd8: c = 2'd2;
            default:          c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/conv_ram.sv -----
// ----------------------------------------------------------------------------
// conv_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module conv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ----- hw/rtl/conv_div.sv -----
// ----------------------------------------------------------------------------
// conv_div
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module conv_div #(
    parameter int DVW = 20,
    parameter int DSW = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic [DVW-1:0] quot,
    output logic [DSW-1:0] rem,
    output logic           done
);

    localparam int CNTW = $clog2(DVW + 1);

    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DVW-1:0]  q_reg;
    logic [DSW-1:0]  r_reg;
    logic [DSW-1:0]  dv_reg;
    logic [DSW:0]    rs;
    logic            fits;
    logic [DSW-1:0]  r_next;
    logic [DVW-1:0]  q_next;

    always_comb
    begin
        rs     = {r_reg, q_reg[DVW-1]};
        fits   = rs >= {1'b0, dv_reg};
        r_next = fits ? DSW'(rs - {1'b0, dv_reg}) : rs[DSW-1:0];
        q_next = {q_reg[DVW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNTW'(DVW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg  <= dividend;
            r_reg  <= '0;
            dv_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quot = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;

endmodule

// ----- hw/rtl/conv_ctrl.sv -----
// ----------------------------------------------------------------------------
// conv_ctrl
// Sequencer: position divide, row bases, nine taps, result divide, output.
// ----------------------------------------------------------------------------
module conv_ctrl
    import conv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic kind,
    input  sts_t sts,
    output logic in_stall,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_ROW,
        S_RD,
        S_MAC,
        S_DST,
        S_RES,
        S_FIN
    } state_t;

    state_t     state_reg;
    logic [1:0] row_reg;
    logic [3:0] tap_reg;
    logic       accept;

    always_comb
    begin
        in_stall      = (state_reg != S_IDLE);
        accept        = in_valid & ~in_stall;
        cmd           = '0;
        cmd.row       = row_reg;
        cmd.tap       = tap_reg;
        cmd.accept    = accept;
        cmd.pos_start = accept & kind;
        case (state_reg)
            S_POS:   cmd.pos_capture = sts.div_done;
            S_ROW:   cmd.row_mul     = 1'b1;
            S_RD:    cmd.tap_rd      = 1'b1;
            S_MAC:   cmd.tap_mac     = 1'b1;
            S_DST:   cmd.res_start   = ~sts.d_zero;
            S_FIN:   cmd.finish      = sts.out_free;
            default: cmd.finish      = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && kind)
                    begin
                        state_reg <= S_POS;
                    end
                end
                S_POS:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= S_ROW;
                        row_reg   <= '0;
                    end
                end
                S_ROW:
                begin
                    row_reg <= row_reg + 1'b1;
                    if (row_reg == ROW_LAST)
                    begin
                        state_reg <= S_RD;
                        tap_reg   <= '0;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (tap_reg == TAP_LAST)
                    begin
                        state_reg <= S_DST;
                    end
                    else
                    begin
                        tap_reg   <= tap_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_DST:
                begin
                    state_reg <= sts.d_zero ? S_FIN : S_RES;
                end
                S_RES:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/conv_dp.sv -----
// ----------------------------------------------------------------------------
// conv_dp
// Datapath: frame store, counters, address generation, MAC, divider, output.
// ----------------------------------------------------------------------------
module conv_dp
    import conv_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic             kind,
    input  logic [PIX_W-1:0] pixel_in,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] pixel_out,
    output logic             frame_done
);

    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CMPW  = (SW > SIDE_REG_W) ? SW : SIDE_REG_W;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DVW   = (CW > ACC_W) ? CW : ACC_W;
    localparam int DSW   = (SW > DIVR_W) ? SW : DIVR_W;

    function automatic logic [SW-1:0] clamp_side(input logic [SIDE_REG_W-1:0] v);
        logic [CMPW-1:0] vv;
        logic [SW-1:0]   r;
        vv = CMPW'(v);
        if (vv < CMPW'(3))
            r = SW'(3);
        else if (vv > CMPW'(MAX_SIDE))
            r = SW'(MAX_SIDE);
        else
            r = SW'(vv);
        return r;
    endfunction

    logic [SW-1:0]   w_c, h_c, w_reg, h_reg, ow;
    logic [2*SW-1:0] prod_full, prod_crop, base_prod;
    logic [CW-1:0]   total_full_reg, total_crop_reg, total_sel;
    logic            phase_reg;
    logic [CW-1:0]   load_cnt_reg, emit_cnt_reg, ec_reg, ec_c;
    logic [SW-1:0]   y_reg, x_reg, ym, yp, xm, xp, yy, xx;
    logic [AW-1:0]   base_reg [3];
    logic [AW-1:0]   rd_addr, wr_addr;
    logic            wr_en;
    logic [PIX_W-1:0] rdata;
    logic [1:0]      tr, tc;
    logic [MASK_W-1:0] mask_sel;
    logic signed [COEF_W-1:0] coef;
    logic signed [COEF_W+PIX_W:0] prod;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [DIVR_W-1:0] msum, dset, dval;
    logic [ACC_W-1:0]  acc_mag;
    logic [DIVR_W-1:0] d_mag;
    logic            neg_reg, dneg_reg;
    logic            div_start, div_done;
    logic [DVW-1:0]  div_dividend, div_quot;
    logic [DSW-1:0]  div_divisor, div_rem;
    logic [PIX_W-1:0] q8, qs, res;
    logic            last;
    logic            out_valid_reg, done_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [MASK_W-1:0] mrow;

    assign w_c       = clamp_side(cfg.frame_width);
    assign h_c       = clamp_side(cfg.frame_height);
    assign prod_full = w_c * h_c;
    assign prod_crop = (w_c - SW'(2)) * (h_c - SW'(2));

    always_ff @(posedge clk)
    begin
        w_reg          <= w_c;
        h_reg          <= h_c;
        total_full_reg <= CW'(prod_full);
        total_crop_reg <= CW'(prod_crop);
    end

    assign total_sel = cfg.crop_mode ? total_crop_reg : total_full_reg;
    assign ow        = cfg.crop_mode ? (w_reg - SW'(2)) : w_reg;
    assign ec_c      = (!phase_reg || emit_cnt_reg >= total_sel) ? '0 : emit_cnt_reg;
    assign last      = (CW'(ec_reg + 1'b1) == total_sel);

    // frame store
    assign wr_en   = cmd.accept & ~kind & (phase_reg | (load_cnt_reg < total_full_reg));
    assign wr_addr = phase_reg ? '0 : load_cnt_reg[AW-1:0];

    // wrapped neighbors
    assign ym = (y_reg == '0) ? (h_reg - 1'b1) : (y_reg - 1'b1);
    assign yp = (y_reg == h_reg - 1'b1) ? '0 : (y_reg + 1'b1);
    assign xm = (x_reg == '0) ? (w_reg - 1'b1) : (x_reg - 1'b1);
    assign xp = (x_reg == w_reg - 1'b1) ? '0 : (x_reg + 1'b1);

    assign tr = tap_row(cmd.tap);
    assign tc = tap_col(cmd.tap);

    always_comb
    begin
        case (cmd.row)
            2'd0:    yy = ym;
            2'd1:    yy = y_reg;
            default: yy = yp;
        endcase
        case (tc)
            2'd0:    xx = xm;
            2'd1:    xx = x_reg;
            default: xx = xp;
        endcase
        case (tr)
            2'd0:    mask_sel = cfg.mask_top_row;
            2'd1:    mask_sel = cfg.mask_middle_row;
            default: mask_sel = cfg.mask_bottom_row;
        endcase
    end

    assign base_prod = yy * w_reg;
    assign rd_addr   = base_reg[tr] + AW'(xx);
    assign coef      = signed'(mask_sel[COEF_W*tc +: COEF_W]);
    assign prod      = signed'({1'b0, rdata}) * coef;

    always_comb
    begin
        msum = '0;
        for (int i = 0; i < 9; i++)
        begin
            case (i / 3)
                0:       mrow = cfg.mask_top_row;
                1:       mrow = cfg.mask_middle_row;
                default: mrow = cfg.mask_bottom_row;
            endcase
            msum = msum + DIVR_W'(signed'(mrow[COEF_W*(i%3) +: COEF_W]));
        end
    end

    assign dset    = signed'(cfg.divider_setting);
    assign dval    = (dset == '0) ? msum : dset;
    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign d_mag   = dval[DIVR_W-1] ? DIVR_W'(-dval) : DIVR_W'(dval);

    assign div_start    = cmd.pos_start | cmd.res_start;
    assign div_dividend = cmd.res_start ? DVW'(acc_mag) : DVW'(ec_c);
    assign div_divisor  = cmd.res_start ? DSW'(d_mag) : DSW'(ow);

    conv_div #(
        .DVW(DVW),
        .DSW(DSW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    conv_ram #(
        .WIDTH(PIX_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (pixel_in),
        .re    (cmd.tap_rd),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign q8  = div_quot[PIX_W-1:0];
    assign qs  = neg_reg ? PIX_W'(-q8) : q8;
    assign res = (dval == '0) ? PIX_W'(acc_reg[PIX_W-1:0] + PIX_W'(128))
                              : PIX_W'(qs + (dneg_reg ? PIX_W'(255) : PIX_W'(0)));

    always_ff @(posedge clk)
    begin
        if (cmd.pos_start)
        begin
            ec_reg <= ec_c;
        end
        if (cmd.pos_capture)
        begin
            y_reg   <= SW'(div_quot) + SW'(cfg.crop_mode);
            x_reg   <= div_rem[SW-1:0] + SW'(cfg.crop_mode);
            acc_reg <= '0;
        end
        if (cmd.row_mul)
        begin
            base_reg[cmd.row] <= AW'(base_prod);
        end
        if (cmd.tap_mac)
        begin
            acc_reg <= acc_reg + ACC_W'(prod);
        end
        if (cmd.res_start)
        begin
            neg_reg  <= acc_reg[ACC_W-1] ^ dval[DIVR_W-1];
            dneg_reg <= dval[DIVR_W-1];
        end
        if (cmd.finish)
        begin
            pix_reg  <= res;
            done_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            load_cnt_reg  <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && !kind)
            begin
                if (phase_reg)
                begin
                    phase_reg    <= 1'b0;
                    emit_cnt_reg <= '0;
                    load_cnt_reg <= CW'(1);
                end
                else if (load_cnt_reg < total_full_reg)
                begin
                    load_cnt_reg <= load_cnt_reg + 1'b1;
                end
            end
            else if (cmd.accept && kind)
            begin
                phase_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (last)
                begin
                    emit_cnt_reg <= '0;
                    load_cnt_reg <= '0;
                    phase_reg    <= 1'b0;
                end
                else
                begin
                    emit_cnt_reg <= CW'(ec_reg + 1'b1);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.div_done = div_done;
    assign sts.d_zero   = (dval == '0);
    assign sts.out_free = ~out_valid_reg | ~out_stall;

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pix_reg;
    assign frame_done = done_reg;

endmodule

// ----- hw/rtl/conv3x3_wrap_filter.sv -----
// ----------------------------------------------------------------------------
// conv3x3_wrap_filter
// 3x3 signed-mask filter with edge wrap over a stored grayscale frame.
// ----------------------------------------------------------------------------
// channel   signals                               direction
// in        in_valid, in_stall, kind, pixel_in    load pixel / request pixel
// out       out_valid, out_stall, pixel_out, ...  filtered pixel
// cfg       psel, penable, pwrite, paddr, ...     APB register port
//
// Accepting a load does not stall the input. A request stalls it until done,
// paced by the shared bit-serial divider (position, then scaling), DVW wide,
// DVW being max(20, bits of the pixel count): 20 at MAX_SIDE 256, and by the
// nine reads of the single frame store port.
// Reset clears counters and control; the frame store is not cleared.
// A finished pixel waits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module conv3x3_wrap_filter
    import conv_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [PIX_W-1:0]  pixel_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PIX_W-1:0]  pixel_out,
    output logic              frame_done,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    cfg_t     cfg_reg;
    cmd_t     cmd;
    sts_t     sts;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= SIDE_REG_W'(256);
            cfg_reg.frame_height    <= SIDE_REG_W'(256);
            cfg_reg.mask_top_row    <= '0;
            cfg_reg.mask_middle_row <= '0;
            cfg_reg.mask_bottom_row <= '0;
            cfg_reg.divider_setting <= '0;
            cfg_reg.crop_mode       <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                REG_WIDTH:    cfg_reg.frame_width     <= pwdata[SIDE_REG_W-1:0];
                REG_HEIGHT:   cfg_reg.frame_height    <= pwdata[SIDE_REG_W-1:0];
                REG_MASK_TOP: cfg_reg.mask_top_row    <= pwdata[MASK_W-1:0];
                REG_MASK_MID: cfg_reg.mask_middle_row <= pwdata[MASK_W-1:0];
                REG_MASK_BOT: cfg_reg.mask_bottom_row <= pwdata[MASK_W-1:0];
                REG_DIVIDER:  cfg_reg.divider_setting <= pwdata[DIVR_W-1:0];
                REG_CROP:     cfg_reg.crop_mode       <= pwdata[0];
                default:      cfg_reg.crop_mode       <= cfg_reg.crop_mode;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_WIDTH:    prdata = CFG_DW'(cfg_reg.frame_width);
            REG_HEIGHT:   prdata = CFG_DW'(cfg_reg.frame_height);
            REG_MASK_TOP: prdata = CFG_DW'(cfg_reg.mask_top_row);
            REG_MASK_MID: prdata = CFG_DW'(cfg_reg.mask_middle_row);
            REG_MASK_BOT: prdata = CFG_DW'(cfg_reg.mask_bottom_row);
            REG_DIVIDER:  prdata = CFG_DW'(cfg_reg.divider_setting);
            REG_CROP:     prdata = CFG_DW'(cfg_reg.crop_mode);
            default:      prdata = '0;
        endcase
    end

    conv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    conv_dp #(
        .MAX_SIDE(MAX_SIDE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .sts        (sts),
        .kind       (kind),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .frame_done (frame_done)
    );

endmodule

// ----- hw/rtl/conv_chk.sv -----
// ----------------------------------------------------------------------------
// conv_chk
// Port-level checks for the filter, bound to the top level.
// ----------------------------------------------------------------------------
module conv_chk
    import conv_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             kind,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIX_W-1:0] pixel_out,
    input logic             frame_done
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_done))
        else $error("stalled output changed");

    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind |=> in_stall)
        else $error("request did not occupy the block");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !kind |=> !in_stall)
        else $error("load stalled the input");

    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a request in progress");

endmodule

bind conv3x3_wrap_filter conv_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .frame_done (frame_done)
);
